@@ design/irm_pkg.sv @@
// Shared constants and codes for the interval range map.
package irm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 8;

    typedef enum logic
    {
        FUNC_ASSIGN = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

@@ design/irm_req_if.sv @@
// Request channel: assign or lookup item with valid/ready handshake.
interface irm_req_if #(
    parameter int KEY_BITS   = irm_pkg::KEY_BITS,
    parameter int VALUE_BITS = irm_pkg::VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    irm_pkg::func_t               func;
    logic signed [KEY_BITS-1:0]   key_begin;
    logic signed [KEY_BITS-1:0]   key_end;
    logic        [VALUE_BITS-1:0] new_value;

    modport source (output valid, func, key_begin, key_end, new_value, input ready);
    modport sink   (input valid, func, key_begin, key_end, new_value, output ready);
endinterface

@@ design/irm_rsp_if.sv @@
// Response channel: lookup value and status with valid/ready handshake.
interface irm_rsp_if #(
    parameter int VALUE_BITS = irm_pkg::VALUE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  read_value;
    irm_pkg::status_t       status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

@@ design/interval_range_map_top.sv @@
// Interval range map: sorted breakpoint table with range assign and key lookup.
//
// Usage:
//   req carries one item: func selects assign (give new_value to keys in
//   [key_begin, key_end)) or lookup (value mapped at key_begin). rsp returns
//   one item per request: read_value (lookup only, zero on assign) and status
//   (done, empty range ignored, table full with nothing changed).
//   cfg_wr_en/cfg_wr_data write initial_value and reset the table to one
//   entry; write only while no request is in flight.
// Sequencing:
//   A sequencer walks the breakpoint table through one RAM read port and one
//   shared key comparator, reading each entry and then processing it. An
//   assign walks every entry, an empty range goes straight to the result, and
//   a lookup walks the entries at or below the key. One item is in work at a
//   time; req.ready is high only while the sequencer is idle, so the next item
//   is accepted only once the result has been registered.
// Reset and stalls:
//   Reset leaves one entry at the lowest key holding zero. A finished result
//   sits in the output register until rsp.ready; the next item is accepted
//   meanwhile, and its result waits until the register frees.
module interval_range_map_top #(
    parameter int TABLE_DEPTH = irm_pkg::TABLE_DEPTH,
    parameter int KEY_BITS    = irm_pkg::KEY_BITS,
    parameter int VALUE_BITS  = irm_pkg::VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [VALUE_BITS-1:0] cfg_wr_data,
    irm_req_if.sink               req,
    irm_rsp_if.source             rsp
);

    localparam int IdxBits  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntBits  = $clog2(TABLE_DEPTH + 1);
    localparam int RamDepth = 2 ** (IdxBits + 1);
    localparam int WordBits = KEY_BITS + VALUE_BITS;

    localparam logic [KEY_BITS-1:0] KeySign = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [CntBits-1:0]  CntFull = CntBits'(TABLE_DEPTH);
    localparam logic [CntBits-1:0]  CntOne  = CntBits'(1);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_PROC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef enum logic [2:0]
    {
        PH_LOW  = 3'b001,
        PH_MID  = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic                   lookup_reg, lookup_next;
    logic [CntBits-1:0]     idx_reg, idx_next;
    logic [CntBits-1:0]     n_reg, n_next;
    logic                   ovf_reg, ovf_next;
    logic                   bank_reg, bank_next;
    logic [CntBits-1:0]     count_reg, count_next;
    logic [VALUE_BITS-1:0]  head_reg, head_next;
    logic                   out_valid_reg, out_valid_next;

    logic [KEY_BITS-1:0]    b_reg, b_next;
    logic [KEY_BITS-1:0]    e_reg, e_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [VALUE_BITS-1:0]  last_val_reg, last_val_next;
    logic [VALUE_BITS-1:0]  end_val_reg, end_val_next;
    logic [VALUE_BITS-1:0]  new_head_reg, new_head_next;
    logic [VALUE_BITS-1:0]  pend_value_reg, pend_value_next;
    irm_pkg::status_t       pend_status_reg, pend_status_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    irm_pkg::status_t       out_status_reg, out_status_next;

    logic                   wr_en;
    logic [IdxBits:0]       wr_addr;
    logic [WordBits-1:0]    wr_data;
    logic [IdxBits:0]       rd_addr;
    logic [WordBits-1:0]    rd_data;

    logic [KEY_BITS-1:0]    in_b;
    logic [KEY_BITS-1:0]    in_e;
    logic [KEY_BITS-1:0]    ent_key;
    logic [VALUE_BITS-1:0]  ent_val;
    logic [KEY_BITS-1:0]    cmp_ref;
    logic                   cmp_lt;
    logic                   cmp_eq;
    logic                   at_end;
    logic                   push_en;
    logic [KEY_BITS-1:0]    push_key;
    logic [VALUE_BITS-1:0]  push_val;
    logic                   push_do;

    irm_ram #(
        .WIDTH (WordBits),
        .DEPTH (RamDepth)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_b    = req.key_begin ^ KeySign;
    assign in_e    = req.key_end ^ KeySign;
    assign rd_addr = {bank_reg, idx_reg[IdxBits-1:0]};
    assign ent_key = (idx_reg == '0) ? '0 : rd_data[WordBits-1 -: KEY_BITS];
    assign ent_val = (idx_reg == '0) ? head_reg : rd_data[VALUE_BITS-1:0];
    assign cmp_ref = (phase_reg == PH_LOW) ? b_reg : e_reg;
    assign cmp_lt  = ent_key < cmp_ref;
    assign cmp_eq  = ent_key == cmp_ref;
    assign at_end  = idx_reg == count_reg;

    assign wr_addr = {~bank_reg, n_reg[IdxBits-1:0]};
    assign wr_data = {push_key, push_val};
    assign wr_en   = push_do && (n_reg != '0) && (n_reg != CntFull);

    assign req.ready      = state_reg == ST_IDLE;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        lookup_next      = lookup_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        ovf_next         = ovf_reg;
        bank_next        = bank_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        out_valid_next   = out_valid_reg;
        b_next           = b_reg;
        e_next           = e_reg;
        val_next         = val_reg;
        last_val_next    = last_val_reg;
        end_val_next     = end_val_reg;
        new_head_next    = new_head_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        push_en          = 1'b0;
        push_key         = ent_key;
        push_val         = ent_val;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    lookup_next     = req.func == irm_pkg::FUNC_LOOKUP;
                    b_next          = in_b;
                    e_next          = (req.func == irm_pkg::FUNC_LOOKUP) ? in_b : in_e;
                    val_next        = req.new_value;
                    idx_next        = '0;
                    n_next          = '0;
                    ovf_next        = 1'b0;
                    end_val_next    = head_reg;
                    pend_value_next = '0;
                    phase_next      = (req.func == irm_pkg::FUNC_LOOKUP) ? PH_MID : PH_LOW;
                    if ((req.func == irm_pkg::FUNC_ASSIGN) && !(in_b < in_e))
                    begin
                        pend_status_next = irm_pkg::STATUS_EMPTY;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        pend_status_next = irm_pkg::STATUS_DONE;
                        state_next       = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        if (!at_end && cmp_lt)
                        begin
                            push_en      = 1'b1;
                            end_val_next = ent_val;
                            idx_next     = idx_reg + CntOne;
                            state_next   = ST_READ;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            push_key   = b_reg;
                            push_val   = val_reg;
                            phase_next = PH_MID;
                        end
                    end
                    PH_MID:
                    begin
                        if (!at_end && (cmp_lt || cmp_eq))
                        begin
                            end_val_next = ent_val;
                            idx_next     = idx_reg + CntOne;
                            state_next   = ST_READ;
                        end
                        else if (lookup_reg)
                        begin
                            pend_value_next = end_val_reg;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            push_key   = e_reg;
                            push_val   = end_val_reg;
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (!at_end)
                        begin
                            push_en    = 1'b1;
                            idx_next   = idx_reg + CntOne;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            if (ovf_reg)
                            begin
                                pend_status_next = irm_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                bank_next  = ~bank_reg;
                                count_next = n_reg;
                                head_next  = new_head_reg;
                            end
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = pend_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        push_do = push_en && !((n_reg != '0) && (last_val_reg == push_val));

        if (push_do)
        begin
            if (n_reg == CntFull)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                n_next        = n_reg + CntOne;
                last_val_next = push_val;
                if (n_reg == '0)
                begin
                    new_head_next = push_val;
                end
            end
        end

        if (cfg_wr_en)
        begin
            head_next  = cfg_wr_data;
            count_next = CntOne;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LOW;
            lookup_reg    <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            count_reg     <= CntOne;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            lookup_reg    <= lookup_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg           <= b_next;
        e_reg           <= e_next;
        val_reg         <= val_next;
        last_val_reg    <= last_val_next;
        end_val_reg     <= end_val_next;
        new_head_reg    <= new_head_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CntFull))
        else $error("entry count out of range");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CntFull)
        else $error("rebuild fill count beyond table depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting an item");

    a_bank_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == ST_PROC))
        else $error("table bank swapped outside a commit");
`endif

endmodule

@@ design/irm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
